// ===== design/rational_quad_bezier_triangle_eval_core_defines.svh =====
// ============================================================================
// rational_quad_bezier_triangle_eval_core_defines: assertion macros
// Concurrent check macros for the evaluator; compiled out with ASSERT_OFF.
// ============================================================================
`ifndef RATIONAL_QUAD_BEZIER_TRIANGLE_EVAL_CORE_DEFINES_SVH
`define RATIONAL_QUAD_BEZIER_TRIANGLE_EVAL_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle.
`define RQBT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition never holds.
`define RQBT_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`else

`define RQBT_ASSERT_IMP(lbl, ante, cons, msg)
`define RQBT_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== design/rqbt_pkg.sv =====
// ============================================================================
// rqbt_pkg: shared types and constants
// Register map, fixed field widths and the divider flag bundle.
// ============================================================================
package rqbt_pkg;

    localparam int PARAM_W    = 16;  // barycentric parameter width
    localparam int CFG_W      = 48;  // configuration register width
    localparam int CFG_IDX_W  = 3;   // configuration index width
    localparam int NUM_REGS   = 8;
    localparam int NUM_POINTS = 6;   // control points and Bernstein terms
    localparam int NUM_COORDS = 3;
    localparam int WEIGHT_W   = 16;  // one packed weight
    localparam int ARITH_W    = 64;  // wrap width of the wide sums

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CORNER_ONE          = 3'd0,
        REG_CORNER_TWO          = 3'd1,
        REG_CORNER_THREE        = 3'd2,
        REG_EDGE_CTRL_ONE_TWO   = 3'd3,
        REG_EDGE_CTRL_ONE_THREE = 3'd4,
        REG_EDGE_CTRL_TWO_THREE = 3'd5,
        REG_CORNER_WEIGHTS      = 3'd6,
        REG_EDGE_WEIGHTS        = 3'd7
    } t_reg_idx;

    // Per-lane status carried alongside the divider data.
    typedef struct packed {
        logic neg;    // quotient is negative
        logic ovf;    // integer quotient already exceeds the coordinate range
        logic wzero;  // weight sum is zero
    } t_div_flags;

endpackage

// ===== design/rational_quad_bezier_triangle_eval_core.sv =====
// ============================================================================
// rational_quad_bezier_triangle_eval_core: rational quadratic Bezier triangle
// Throughput: one item per cycle; the pipeline and its bubble-collapsing valid
// chain let a new item enter every cycle, and while a result is stalled as
// long as some stage is still empty.
// Reset: synchronous, active low; empties the pipeline and restores the
// registers (points 0, all weights 1.0).
// ============================================================================
`include "rational_quad_bezier_triangle_eval_core_defines.svh"

module rational_quad_bezier_triangle_eval_core #(
    parameter int COORD_WIDTH      = 16,
    parameter int PARAM_FRAC_BITS  = 15,
    parameter int WEIGHT_FRAC_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // parameter channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rqbt_pkg::PARAM_W-1:0]        i_param_s,
    input  logic [rqbt_pkg::PARAM_W-1:0]        i_param_u,
    input  logic [rqbt_pkg::PARAM_W-1:0]        i_param_v,
    input  logic                                i_auto_v,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [COORD_WIDTH-1:0]       o_out_x,
    output logic signed [COORD_WIDTH-1:0]       o_out_y,
    output logic signed [COORD_WIDTH-1:0]       o_out_z,
    output logic                                o_weight_zero,
    output logic                                o_clipped,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rqbt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rqbt_pkg::CFG_W-1:0]          i_cfg_data
);
    import rqbt_pkg::*;

    // Datapath widths. v may go negative with auto_v, so the basis terms
    // are signed; the wide sums wrap at ARITH_W bits.
    localparam int V_W    = ((PARAM_W > PARAM_FRAC_BITS) ? PARAM_W : PARAM_FRAC_BITS + 1) + 2;
    localparam int PROD_W = 2 * V_W + 1;
    localparam int B_W    = PROD_W - PARAM_FRAC_BITS;
    localparam int WB_W   = B_W + WEIGHT_W + 1;
    localparam int WSUM_W = (WB_W + 3 > ARITH_W) ? ARITH_W : WB_W + 3;
    localparam int NUM_W  = (COORD_WIDTH + WB_W + 3 > ARITH_W) ?
                            ARITH_W : COORD_WIDTH + WB_W + 3;
    localparam int DIV_W  = (NUM_W > WSUM_W + COORD_WIDTH) ? NUM_W : WSUM_W + COORD_WIDTH;
    localparam int CMP_W  = ((NUM_W > WSUM_W) ? NUM_W : WSUM_W) + 1;

    localparam logic [WEIGHT_W-1:0] W_ONE   = WEIGHT_W'(64'd1 << WEIGHT_FRAC_BITS);
    localparam logic [CFG_W-1:0]    W_RESET = {W_ONE, W_ONE, W_ONE};

    // Saturation limits of the rounded magnitude, one bit wider than a coordinate.
    localparam logic [COORD_WIDTH:0] LIM_POS = ((COORD_WIDTH + 1)'(1) << (COORD_WIDTH - 1))
                                             - (COORD_WIDTH + 1)'(1);
    localparam logic [COORD_WIDTH:0] LIM_NEG = (COORD_WIDTH + 1)'(1) << (COORD_WIDTH - 1);
    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // ------------------------------------------------------------------------
    // Configuration registers. Writes are always taken; software must write only while
    // the pipeline is empty (the block does not enforce it), as the stages read them directly.
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] r_cfg [NUM_REGS];
    logic [NUM_POINTS-1:0][CFG_W-1:0] points;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= (k == int'(REG_CORNER_WEIGHTS) || k == int'(REG_EDGE_WEIGHTS))
                          ? W_RESET : '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Point k of the basis ordering is register k.
    always_comb begin
        for (int k = 0; k < NUM_POINTS; k++) points[k] = r_cfg[k];
    end

    // ------------------------------------------------------------------------
    // Stages 1-4: basis terms, weights, point products, lane sums.
    // ------------------------------------------------------------------------
    logic                     w_valid, w_ready, w_in_ready;
    logic signed [NUM_W-1:0]  w_num [NUM_COORDS];
    logic signed [WSUM_W-1:0] w_wsum;

    rqbt_weight #(
        .COORD_WIDTH     (COORD_WIDTH),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS),
        .V_W             (V_W),
        .B_W             (B_W),
        .WB_W            (WB_W),
        .WSUM_W          (WSUM_W),
        .NUM_W           (NUM_W)
    ) u_weight (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_ready          (w_in_ready),
        .i_param_s        (i_param_s),
        .i_param_u        (i_param_u),
        .i_param_v        (i_param_v),
        .i_auto_v         (i_auto_v),
        .i_points         (points),
        .i_corner_weights (r_cfg[REG_CORNER_WEIGHTS]),
        .i_edge_weights   (r_cfg[REG_EDGE_WEIGHTS]),
        .o_valid          (w_valid),
        .i_ready          (w_ready),
        .o_num            (w_num),
        .o_wsum           (w_wsum)
    );

    // Stall upstream only when every stage holds an item that cannot move.
    assign o_in_stall = !w_in_ready;

    // ------------------------------------------------------------------------
    // Stages 5-6: magnitudes, signs, zero weight and range check.
    // ------------------------------------------------------------------------
    logic                   d_valid [COORD_WIDTH+1];
    logic                   d_ready [COORD_WIDTH+1];
    logic [NUM_W-1:0]       d_rem   [COORD_WIDTH+1][NUM_COORDS];
    logic [COORD_WIDTH-1:0] d_quo   [COORD_WIDTH+1][NUM_COORDS];
    logic [WSUM_W-1:0]      d_aw    [COORD_WIDTH+1];
    t_div_flags             d_flags [COORD_WIDTH+1][NUM_COORDS];

    rqbt_norm #(
        .COORD_WIDTH (COORD_WIDTH),
        .WSUM_W      (WSUM_W),
        .NUM_W       (NUM_W),
        .DIV_W       (DIV_W)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .o_ready (w_ready),
        .i_num   (w_num),
        .i_wsum  (w_wsum),
        .o_valid (d_valid[0]),
        .i_ready (d_ready[0]),
        .o_an    (d_rem[0]),
        .o_aw    (d_aw[0]),
        .o_flags (d_flags[0])
    );

    always_comb begin
        for (int c = 0; c < NUM_COORDS; c++) d_quo[0][c] = '0;
    end

    // ------------------------------------------------------------------------
    // Division: one quotient bit per stage, most significant first. The range
    // check guarantees the quotient fits in COORD_WIDTH bits unless flagged.
    // ------------------------------------------------------------------------
    for (genvar j = 0; j < COORD_WIDTH; j++) begin : g_div
        rqbt_div_step #(
            .COORD_WIDTH (COORD_WIDTH),
            .STEP        (COORD_WIDTH - 1 - j),
            .WSUM_W      (WSUM_W),
            .NUM_W       (NUM_W),
            .DIV_W       (DIV_W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d_valid[j]),
            .o_ready (d_ready[j]),
            .i_rem   (d_rem[j]),
            .i_quo   (d_quo[j]),
            .i_aw    (d_aw[j]),
            .i_flags (d_flags[j]),
            .o_valid (d_valid[j+1]),
            .i_ready (d_ready[j+1]),
            .o_rem   (d_rem[j+1]),
            .o_quo   (d_quo[j+1]),
            .o_aw    (d_aw[j+1]),
            .o_flags (d_flags[j+1])
        );
    end

    // ------------------------------------------------------------------------
    // Output stage: round half away from zero on the magnitude, saturate,
    // apply the sign. A zero weight sum forces zeros and clears clipping.
    // ------------------------------------------------------------------------
    logic [CMP_W-1:0]              rem_x2 [NUM_COORDS];
    logic [CMP_W-1:0]              aw_x;
    logic                          rnd    [NUM_COORDS];
    logic [COORD_WIDTH:0]          q_r    [NUM_COORDS];
    logic [COORD_WIDTH:0]          lim    [NUM_COORDS];
    logic [COORD_WIDTH:0]          q_m    [NUM_COORDS];
    logic                          sat    [NUM_COORDS];
    logic signed [COORD_WIDTH-1:0] n_res  [NUM_COORDS];
    logic                          n_clip;
    logic                          n_wzero;
    logic                          out_rdy;

    logic                          r_out_valid;
    logic signed [COORD_WIDTH-1:0] r_res [NUM_COORDS];
    logic                          r_wzero;
    logic                          r_clip;

    always_comb begin
        aw_x    = CMP_W'(d_aw[COORD_WIDTH]);
        n_wzero = d_flags[COORD_WIDTH][0].wzero;
        n_clip  = 1'b0;
        for (int c = 0; c < NUM_COORDS; c++) begin
            rem_x2[c] = CMP_W'(d_rem[COORD_WIDTH][c]) << 1;
            rnd[c]    = (rem_x2[c] >= aw_x);
            q_r[c]    = (COORD_WIDTH + 1)'(d_quo[COORD_WIDTH][c])
                      + (COORD_WIDTH + 1)'(rnd[c]);
            lim[c]    = d_flags[COORD_WIDTH][c].neg ? LIM_NEG : LIM_POS;
            sat[c]    = d_flags[COORD_WIDTH][c].ovf || (q_r[c] > lim[c]);
            q_m[c]    = sat[c] ? lim[c] : q_r[c];
            n_res[c]  = d_flags[COORD_WIDTH][c].neg ? -q_m[c][COORD_WIDTH-1:0]
                                                    :  q_m[c][COORD_WIDTH-1:0];
            if (n_wzero) begin
                n_res[c] = '0;
                sat[c]   = 1'b0;
            end
            n_clip = n_clip || sat[c];
        end
    end

    // Output register parts the result channel from the pipeline.
    assign out_rdy                = !r_out_valid || !i_out_stall;
    assign d_ready[COORD_WIDTH]   = out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_rdy) begin
            r_out_valid <= d_valid[COORD_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_wzero <= n_wzero;
            r_clip  <= n_clip;
            for (int c = 0; c < NUM_COORDS; c++) r_res[c] <= n_res[c];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_res[0];
    assign o_out_y       = r_res[1];
    assign o_out_z       = r_res[2];
    assign o_weight_zero = r_wzero;
    assign o_clipped     = r_clip;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    `RQBT_ASSERT_IMP(a_zero_weight_clears, o_out_valid && o_weight_zero, o_out_x == '0 && o_out_y == '0 && o_out_z == '0, "zero weight sum left a nonzero coordinate")
    `RQBT_ASSERT_NEVER(a_zero_weight_no_clip, o_out_valid && o_weight_zero && o_clipped, "clip flagged on a zero weight result")
    `RQBT_ASSERT_IMP(a_clip_at_limit, o_out_valid && o_clipped, o_out_x == C_MAX || o_out_x == C_MIN || o_out_y == C_MAX || o_out_y == C_MIN || o_out_z == C_MAX || o_out_z == C_MIN, "clip flagged with no coordinate at a limit")
    `RQBT_ASSERT_IMP(a_stall_needs_backpressure, o_in_stall, o_out_valid && i_out_stall, "input stalled without a stalled result")

endmodule

// ===== design/rqbt_weight.sv =====
// ============================================================================
// rqbt_weight: Bernstein basis and weighted sums
// Four stages: basis terms, weight products, point products, lane sums.
// ============================================================================
module rqbt_weight #(
    parameter int COORD_WIDTH     = 16,
    parameter int PARAM_FRAC_BITS = 15,
    parameter int V_W             = 18,
    parameter int B_W             = 22,
    parameter int WB_W            = 39,
    parameter int WSUM_W          = 42,
    parameter int NUM_W           = 58
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   i_valid,
    output logic                                                   o_ready,
    input  logic [rqbt_pkg::PARAM_W-1:0]                           i_param_s,
    input  logic [rqbt_pkg::PARAM_W-1:0]                           i_param_u,
    input  logic [rqbt_pkg::PARAM_W-1:0]                           i_param_v,
    input  logic                                                   i_auto_v,
    input  logic [rqbt_pkg::NUM_POINTS-1:0][rqbt_pkg::CFG_W-1:0]   i_points,
    input  logic [rqbt_pkg::CFG_W-1:0]                             i_corner_weights,
    input  logic [rqbt_pkg::CFG_W-1:0]                             i_edge_weights,
    output logic                                                   o_valid,
    input  logic                                                   i_ready,
    output logic signed [NUM_W-1:0]                                o_num [rqbt_pkg::NUM_COORDS],
    output logic signed [WSUM_W-1:0]                               o_wsum
);
    import rqbt_pkg::*;

    localparam int PROD_W = 2 * V_W + 1;
    localparam int TERM_W = COORD_WIDTH + WB_W;
    localparam int PT_W   = (NUM_COORDS * COORD_WIDTH > CFG_W) ?
                            NUM_COORDS * COORD_WIDTH : CFG_W;
    localparam int NSTG   = 4;
    localparam logic [V_W-1:0] P_ONE = V_W'(1) << PARAM_FRAC_BITS;

    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] r_vld;

    logic signed [V_W-1:0]    s_x, u_x, v_x;
    logic signed [PROD_W-1:0] prod  [NUM_POINTS];
    logic signed [B_W-1:0]    n_b   [NUM_POINTS];
    logic signed [B_W-1:0]    r_b   [NUM_POINTS];

    logic [WEIGHT_W-1:0]      wt    [NUM_POINTS];
    logic signed [WB_W-1:0]   n_wb  [NUM_POINTS];
    logic signed [WB_W-1:0]   r_wb  [NUM_POINTS];

    logic [PT_W-1:0]             pt_ext [NUM_POINTS];
    logic signed [COORD_WIDTH-1:0] coord [NUM_POINTS][NUM_COORDS];
    logic signed [TERM_W-1:0]    prodt  [NUM_POINTS][NUM_COORDS];
    logic signed [NUM_W-1:0]     n_term [NUM_POINTS][NUM_COORDS];
    logic signed [NUM_W-1:0]     r_term [NUM_POINTS][NUM_COORDS];
    logic signed [WSUM_W-1:0]    n_wsum, r_wsum3, r_wsum4;

    logic signed [NUM_W-1:0]     n_num [NUM_COORDS];
    logic signed [NUM_W-1:0]     r_num [NUM_COORDS];

    // A stage takes new data when it is empty or its content moves on.
    always_comb begin
        rdy[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 1: basis terms, floored to the parameter fraction.
    always_comb begin
        s_x = V_W'(i_param_s);
        u_x = V_W'(i_param_u);
        if (i_auto_v) begin
            v_x = P_ONE - s_x - u_x;
        end else begin
            v_x = V_W'(i_param_v);
        end
        prod[0] = s_x * s_x;
        prod[1] = u_x * u_x;
        prod[2] = v_x * v_x;
        prod[3] = (s_x * u_x) <<< 1;
        prod[4] = (s_x * v_x) <<< 1;
        prod[5] = (u_x * v_x) <<< 1;
        for (int i = 0; i < NUM_POINTS; i++) begin
            n_b[i] = prod[i][PROD_W-1:PARAM_FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int i = 0; i < NUM_POINTS; i++) r_b[i] <= n_b[i];
        end
    end

    // Stage 2: weight each basis term.
    always_comb begin
        for (int i = 0; i < NUM_COORDS; i++) begin
            wt[i]              = i_corner_weights[i*WEIGHT_W +: WEIGHT_W];
            wt[i + NUM_COORDS] = i_edge_weights[i*WEIGHT_W +: WEIGHT_W];
        end
        for (int i = 0; i < NUM_POINTS; i++) begin
            n_wb[i] = $signed({1'b0, wt[i]}) * r_b[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            for (int i = 0; i < NUM_POINTS; i++) r_wb[i] <= n_wb[i];
        end
    end

    // Stage 3: point coordinate times weighted term; weight sum.
    always_comb begin
        n_wsum = '0;
        for (int i = 0; i < NUM_POINTS; i++) begin
            pt_ext[i] = PT_W'(i_points[i]);
            n_wsum    = n_wsum + WSUM_W'(r_wb[i]);
            for (int c = 0; c < NUM_COORDS; c++) begin
                coord[i][c]  = pt_ext[i][c*COORD_WIDTH +: COORD_WIDTH];
                prodt[i][c]  = coord[i][c] * r_wb[i];
                n_term[i][c] = NUM_W'(prodt[i][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_wsum3 <= n_wsum;
            for (int i = 0; i < NUM_POINTS; i++) begin
                for (int c = 0; c < NUM_COORDS; c++) r_term[i][c] <= n_term[i][c];
            end
        end
    end

    // Stage 4: sum the six terms of each lane.
    always_comb begin
        for (int c = 0; c < NUM_COORDS; c++) begin
            n_num[c] = r_term[0][c] + r_term[1][c] + r_term[2][c]
                     + r_term[3][c] + r_term[4][c] + r_term[5][c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_wsum4 <= r_wsum3;
            for (int c = 0; c < NUM_COORDS; c++) r_num[c] <= n_num[c];
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_wsum  = r_wsum4;
    always_comb begin
        for (int c = 0; c < NUM_COORDS; c++) o_num[c] = r_num[c];
    end

endmodule

// ===== design/rqbt_norm.sv =====
// ============================================================================
// rqbt_norm: divider operand preparation
// Two stages: magnitudes and signs, then the quotient range check.
// ============================================================================
module rqbt_norm #(
    parameter int COORD_WIDTH = 16,
    parameter int WSUM_W      = 42,
    parameter int NUM_W       = 58,
    parameter int DIV_W       = 58
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [NUM_W-1:0]     i_num [rqbt_pkg::NUM_COORDS],
    input  logic signed [WSUM_W-1:0]    i_wsum,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [NUM_W-1:0]            o_an [rqbt_pkg::NUM_COORDS],
    output logic [WSUM_W-1:0]           o_aw,
    output rqbt_pkg::t_div_flags        o_flags [rqbt_pkg::NUM_COORDS]
);
    import rqbt_pkg::*;

    logic [2:0] rdy;
    logic [1:0] r_vld;

    logic [NUM_W-1:0]  n_an  [NUM_COORDS];
    logic [NUM_W-1:0]  r_an5 [NUM_COORDS];
    logic [NUM_W-1:0]  r_an6 [NUM_COORDS];
    logic [WSUM_W-1:0] n_aw, r_aw5, r_aw6;
    t_div_flags        n_fl5 [NUM_COORDS];
    t_div_flags        r_fl5 [NUM_COORDS];
    t_div_flags        n_fl6 [NUM_COORDS];
    t_div_flags        r_fl6 [NUM_COORDS];
    logic [DIV_W-1:0]  aw_top;

    always_comb begin
        rdy[2] = i_ready;
        rdy[1] = !r_vld[1] || rdy[2];
        rdy[0] = !r_vld[0] || rdy[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            if (rdy[1]) r_vld[1] <= r_vld[0];
        end
    end

    // Stage 5: magnitudes, quotient sign, zero weight.
    always_comb begin
        n_aw = i_wsum[WSUM_W-1] ? WSUM_W'(-i_wsum) : WSUM_W'(i_wsum);
        for (int c = 0; c < NUM_COORDS; c++) begin
            n_an[c]        = i_num[c][NUM_W-1] ? NUM_W'(-i_num[c]) : NUM_W'(i_num[c]);
            n_fl5[c].neg   = i_num[c][NUM_W-1] ^ i_wsum[WSUM_W-1];
            n_fl5[c].ovf   = 1'b0;
            n_fl5[c].wzero = (i_wsum == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_aw5 <= n_aw;
            for (int c = 0; c < NUM_COORDS; c++) begin
                r_an5[c] <= n_an[c];
                r_fl5[c] <= n_fl5[c];
            end
        end
    end

    // Stage 6: flag quotients whose integer part needs more than COORD_WIDTH bits.
    always_comb begin
        aw_top = DIV_W'(r_aw5) << COORD_WIDTH;
        for (int c = 0; c < NUM_COORDS; c++) begin
            n_fl6[c]     = r_fl5[c];
            n_fl6[c].ovf = (DIV_W'(r_an5[c]) >= aw_top);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_aw6 <= r_aw5;
            for (int c = 0; c < NUM_COORDS; c++) begin
                r_an6[c] <= r_an5[c];
                r_fl6[c] <= n_fl6[c];
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[1];
    assign o_aw    = r_aw6;
    always_comb begin
        for (int c = 0; c < NUM_COORDS; c++) begin
            o_an[c]    = r_an6[c];
            o_flags[c] = r_fl6[c];
        end
    end

endmodule

// ===== design/rqbt_div_step.sv =====
// ============================================================================
// rqbt_div_step: one restoring division stage
// Resolves quotient bit STEP of all three lanes against the shared divisor.
// ============================================================================
module rqbt_div_step #(
    parameter int COORD_WIDTH = 16,
    parameter int STEP        = 15,
    parameter int WSUM_W      = 42,
    parameter int NUM_W       = 58,
    parameter int DIV_W       = 58
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [NUM_W-1:0]            i_rem   [rqbt_pkg::NUM_COORDS],
    input  logic [COORD_WIDTH-1:0]      i_quo   [rqbt_pkg::NUM_COORDS],
    input  logic [WSUM_W-1:0]           i_aw,
    input  rqbt_pkg::t_div_flags        i_flags [rqbt_pkg::NUM_COORDS],
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [NUM_W-1:0]            o_rem   [rqbt_pkg::NUM_COORDS],
    output logic [COORD_WIDTH-1:0]      o_quo   [rqbt_pkg::NUM_COORDS],
    output logic [WSUM_W-1:0]           o_aw,
    output rqbt_pkg::t_div_flags        o_flags [rqbt_pkg::NUM_COORDS]
);
    import rqbt_pkg::*;

    logic                   rdy;
    logic                   r_vld;
    logic [DIV_W-1:0]       trial;
    logic [DIV_W:0]         diff  [NUM_COORDS];
    logic [NUM_W-1:0]       n_rem [NUM_COORDS];
    logic [COORD_WIDTH-1:0] n_quo [NUM_COORDS];
    logic [NUM_W-1:0]       r_rem [NUM_COORDS];
    logic [COORD_WIDTH-1:0] r_quo [NUM_COORDS];
    logic [WSUM_W-1:0]      r_aw;
    t_div_flags             r_flags [NUM_COORDS];

    assign rdy = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (rdy) begin
            r_vld <= i_valid;
        end
    end

    // Subtract the shifted divisor; a clear borrow sets the quotient bit.
    always_comb begin
        trial = DIV_W'(i_aw) << STEP;
        for (int c = 0; c < NUM_COORDS; c++) begin
            diff[c]        = {1'b0, DIV_W'(i_rem[c])} - {1'b0, trial};
            n_quo[c]       = i_quo[c];
            n_quo[c][STEP] = !diff[c][DIV_W];
            n_rem[c]       = diff[c][DIV_W] ? i_rem[c] : diff[c][NUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy) begin
            r_aw <= i_aw;
            for (int c = 0; c < NUM_COORDS; c++) begin
                r_rem[c]   <= n_rem[c];
                r_quo[c]   <= n_quo[c];
                r_flags[c] <= i_flags[c];
            end
        end
    end

    assign o_ready = rdy;
    assign o_valid = r_vld;
    assign o_aw    = r_aw;
    always_comb begin
        for (int c = 0; c < NUM_COORDS; c++) begin
            o_rem[c]   = r_rem[c];
            o_quo[c]   = r_quo[c];
            o_flags[c] = r_flags[c];
        end
    end

endmodule
